@@ rtl/core/gain_scheduled_pd_steering_defines.svh @@
// Assertion helpers shared by the steering core.
`ifndef GAIN_SCHEDULED_PD_STEERING_DEFINES_SVH
`define GAIN_SCHEDULED_PD_STEERING_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define GSP_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define GSP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/gsp_pkg.sv @@
package gsp_pkg;

    typedef struct packed {
        logic signed [9:0] track_error;
        logic              short_straight;
        logic [3:0]        corner_count;
        logic [5:0]        valid_lines;
        logic              stop_line;
        logic              roundabout;
        logic              crossroad;
        logic [5:0]        straight_run;
    } t_in_item;

    typedef struct packed {
        logic signed [15:0] steer_offset;
        logic [3:0]         road_class;
    } t_out_item;

    localparam int MacSteps = 12;
    localparam int MacMcW   = 18;
    localparam int MacHiW   = 20;
    localparam int MacCntW  = 4;

    localparam logic [3:0] CLS_SHORT_STRAIGHT   = 4'd0;
    localparam logic [3:0] CLS_LONG_STRAIGHT    = 4'd1;
    localparam logic [3:0] CLS_LOOP             = 4'd2;
    localparam logic [3:0] CLS_CROSSROAD        = 4'd3;
    localparam logic [3:0] CLS_SMALL_S          = 4'd4;
    localparam logic [3:0] CLS_MEDIUM_S         = 4'd5;
    localparam logic [3:0] CLS_LARGE_S          = 4'd6;
    localparam logic [3:0] CLS_SMALL_CURVE      = 4'd7;
    localparam logic [3:0] CLS_MEDIUM_CURVE     = 4'd8;
    localparam logic [3:0] CLS_LARGE_CURVE      = 4'd9;
    localparam logic [3:0] CLS_VERY_LARGE_CURVE = 4'd10;

    localparam logic [2:0] CFG_GAIN_LOW   = 3'd0;
    localparam logic [2:0] CFG_GAIN_MID   = 3'd1;
    localparam logic [2:0] CFG_GAIN_HIGH  = 3'd2;
    localparam logic [2:0] CFG_GAIN_OFS   = 3'd3;
    localparam logic [2:0] CFG_DERIV_GAIN = 3'd4;
    localparam logic [2:0] CFG_STEER_UP   = 3'd5;
    localparam logic [2:0] CFG_STEER_LO   = 3'd6;

    localparam logic [5:0] LINES_LONG_STRAIGHT = 6'd52;
    localparam logic [5:0] LINES_S_BEND        = 6'd48;
    localparam logic [5:0] RUN_SMALL_S         = 6'd40;
    localparam logic [5:0] RUN_MEDIUM_S        = 6'd25;
    localparam logic [5:0] LINES_SMALL_CURVE   = 6'd45;
    localparam logic [5:0] LINES_MEDIUM_CURVE  = 6'd37;
    localparam logic [5:0] LINES_LARGE_CURVE   = 6'd30;

    // floor(d2 / 22) == (d2 * 5958) >> 17 for every d2 below 4096
    localparam logic [12:0] QUAD_RECIP = 13'd5958;
    localparam int          QuadShift  = 17;

    function automatic logic signed [15:0] class_gain(
        input logic [63:0] tbl_low,
        input logic [63:0] tbl_mid,
        input logic [63:0] tbl_high,
        input logic [3:0]  cls
    );
        logic [63:0] t;
        logic [15:0] g;
        case (cls[3:2])
            2'b00:   t = tbl_low;
            2'b01:   t = tbl_mid;
            default: t = tbl_high;
        endcase
        case (cls[1:0])
            2'b00:   g = t[15:0];
            2'b01:   g = t[31:16];
            2'b10:   g = t[47:32];
            default: g = t[63:48];
        endcase
        return $signed(g);
    endfunction

endpackage

@@ rtl/core/gain_scheduled_pd_steering.sv @@
// Gain-scheduled PD steering core.
// Input channel: i_in_valid / o_in_stall with a t_in_item payload; an item
// transfers on a rising edge with valid high and stall low.
// Output channel: o_out_valid / i_out_stall with a t_out_item payload, held
// in an output register until it transfers.
// Config channel: i_cfg_valid / o_cfg_ready, register index and 64-bit data;
// ready is always high. Write only while no item is in flight.
// Sequence: S_QUO builds the total gain and loads the multiplier, S_MUL runs
// the twelve steps of the bit-serial dual multiplier (one multiplier bit per
// cycle) and waits for its done flag, S_FIN scales and clamps, and S_HOLD
// moves the result to the output register.
// A new item is taken only after the previous result moves to the output
// register; it is taken while that result still waits there. A result that
// finds the register full waits in S_HOLD and keeps o_in_stall high.
// Reset clears the config registers, the held class, the previous error
// and the output valid.
`include "gain_scheduled_pd_steering_defines.svh"

module gain_scheduled_pd_steering import gsp_pkg::*; #(
    parameter int LINES = 60
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  t_in_item   i_in_data,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output t_out_item  o_out_data,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [2:0] i_cfg_index,
    input  logic [63:0] i_cfg_data
);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_QUO  = 5'b00010,
        S_MUL  = 5'b00100,
        S_FIN  = 5'b01000,
        S_HOLD = 5'b10000
    } t_state;

    localparam logic [5:0] LinesV = 6'(LINES);

    t_state              r_state;
    t_state              n_state;

    logic [63:0]         r_gain_low;
    logic [63:0]         r_gain_mid;
    logic [63:0]         r_gain_high;
    logic signed [15:0]  r_gain_ofs;
    logic signed [15:0]  r_deriv_gain;
    logic [14:0]         r_steer_up;
    logic signed [15:0]  r_steer_lo;

    logic signed [10:0]  r_prev;
    logic [3:0]          r_held;
    logic                r_out_valid;
    t_out_item           r_out;

    logic signed [16:0]  r_kp_part;
    logic [11:0]         r_d2;
    logic signed [10:0]  r_e;
    logic signed [11:0]  r_de;
    logic signed [15:0]  r_res;

    logic                w_accept;
    logic                w_load_out;
    logic                w_no_corner;
    logic                w_upd;
    logic                w_stop;
    logic [3:0]          w_cls;
    logic signed [15:0]  w_kp;
    logic [5:0]          w_lines_eff;
    logic signed [7:0]   w_d;
    logic signed [15:0]  w_d2;
    logic signed [10:0]  w_e;
    logic signed [11:0]  w_de;
    logic signed [16:0]  w_kp_part;
    logic [24:0]         w_qprod;
    logic [7:0]          w_q;
    logic signed [17:0]  w_kp_total;
    logic                w_mac_start;
    logic                w_mac_done;
    logic signed [31:0]  w_p;
    logic signed [31:0]  w_pr;
    logic signed [31:0]  w_pq;
    logic signed [31:0]  w_up;
    logic signed [31:0]  w_lo;
    logic signed [31:0]  w_c1;
    logic signed [31:0]  w_c2;

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign w_accept    = i_in_valid && !o_in_stall;
    assign w_load_out  = (r_state == S_HOLD) && (!r_out_valid || !i_out_stall);

    always_comb begin
        w_no_corner = (i_in_data.corner_count == 4'd0);
        w_upd       = 1'b1;
        w_stop      = 1'b0;
        w_cls       = r_held;
        if (i_in_data.short_straight && w_no_corner) begin
            w_cls = CLS_SHORT_STRAIGHT;
        end else if ((i_in_data.valid_lines > LINES_LONG_STRAIGHT) && w_no_corner) begin
            w_cls = CLS_LONG_STRAIGHT;
        end else if (i_in_data.stop_line) begin
            w_upd  = 1'b0;
            w_stop = 1'b1;
        end else if (i_in_data.roundabout) begin
            w_upd = 1'b0;
            w_cls = CLS_LOOP;
        end else if (i_in_data.crossroad) begin
            w_cls = CLS_CROSSROAD;
        end else if ((i_in_data.valid_lines >= LINES_S_BEND) && !w_no_corner) begin
            if (i_in_data.straight_run > RUN_SMALL_S) begin
                w_cls = CLS_SMALL_S;
            end else if (i_in_data.straight_run > RUN_MEDIUM_S) begin
                w_cls = CLS_MEDIUM_S;
            end else begin
                w_cls = CLS_LARGE_S;
            end
        end else begin
            if (i_in_data.valid_lines > LINES_SMALL_CURVE) begin
                w_cls = CLS_SMALL_CURVE;
            end else if (i_in_data.valid_lines > LINES_MEDIUM_CURVE) begin
                w_cls = CLS_MEDIUM_CURVE;
            end else if (i_in_data.valid_lines > LINES_LARGE_CURVE) begin
                w_cls = CLS_LARGE_CURVE;
            end else begin
                w_cls = CLS_VERY_LARGE_CURVE;
            end
        end
        w_kp = w_stop ? 16'sd0 : class_gain(r_gain_low, r_gain_mid, r_gain_high, w_cls);
    end

    assign w_lines_eff = w_stop ? LinesV : i_in_data.valid_lines;
    assign w_d         = $signed({2'b00, LinesV}) - $signed({2'b00, w_lines_eff});
    assign w_d2        = w_d * w_d;
    assign w_e         = 11'sd0 - $signed({i_in_data.track_error[9], i_in_data.track_error});
    assign w_de        = $signed({w_e[10], w_e}) - $signed({r_prev[10], r_prev});
    assign w_kp_part   = $signed({w_kp[15], w_kp}) + $signed({r_gain_ofs[15], r_gain_ofs});

    assign w_qprod     = 25'(r_d2) * 25'(QUAD_RECIP);
    assign w_q         = w_qprod[QuadShift+7:QuadShift];
    assign w_kp_total  = $signed({r_kp_part[16], r_kp_part}) + $signed({6'b0, w_q, 4'b0});
    assign w_mac_start = (r_state == S_QUO);

    gsp_serial_mac u_mac (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (w_mac_start),
        .i_a       (w_kp_total),
        .i_b       ({{(MacMcW - 16){r_deriv_gain[15]}}, r_deriv_gain}),
        .i_ma      ({r_e[10], r_e}),
        .i_mb      (r_de),
        .o_done    (w_mac_done),
        .o_product (w_p)
    );

    // divide by 16 toward zero, then upper clamp before lower clamp
    assign w_pr = w_p + (w_p[31] ? 32'sd15 : 32'sd0);
    assign w_pq = w_pr >>> 4;
    assign w_up = $signed({17'b0, r_steer_up});
    assign w_lo = {{16{r_steer_lo[15]}}, r_steer_lo};
    assign w_c1 = (w_pq > w_up) ? w_up : w_pq;
    assign w_c2 = (w_c1 < w_lo) ? w_lo : w_c1;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_QUO;
                end
            end
            S_QUO: begin
                n_state = S_MUL;
            end
            S_MUL: begin
                if (w_mac_done) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                n_state = S_HOLD;
            end
            S_HOLD: begin
                if (w_load_out) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_gain_low   <= '0;
            r_gain_mid   <= '0;
            r_gain_high  <= '0;
            r_gain_ofs   <= '0;
            r_deriv_gain <= '0;
            r_steer_up   <= '0;
            r_steer_lo   <= '0;
            r_prev       <= '0;
            r_held       <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_GAIN_LOW:   r_gain_low   <= i_cfg_data;
                    CFG_GAIN_MID:   r_gain_mid   <= i_cfg_data;
                    CFG_GAIN_HIGH:  r_gain_high  <= i_cfg_data;
                    CFG_GAIN_OFS:   r_gain_ofs   <= $signed(i_cfg_data[15:0]);
                    CFG_DERIV_GAIN: r_deriv_gain <= $signed(i_cfg_data[15:0]);
                    CFG_STEER_UP:   r_steer_up   <= i_cfg_data[14:0];
                    CFG_STEER_LO:   r_steer_lo   <= $signed(i_cfg_data[15:0]);
                    default: begin
                    end
                endcase
            end
            if (w_accept) begin
                r_prev <= w_e;
                if (w_upd) begin
                    r_held <= w_cls;
                end
            end
            if (w_load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_kp_part <= w_kp_part;
            r_d2      <= w_d2[11:0];
            r_e       <= w_e;
            r_de      <= w_de;
        end
        if (r_state == S_FIN) begin
            r_res <= w_c2[15:0];
        end
        if (w_load_out) begin
            r_out.steer_offset <= r_res;
            r_out.road_class   <= r_held;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    `GSP_ASSERT_NEXT(a_accept_to_gain, i_clk, i_rst_n, w_accept, r_state == S_QUO, "accepted item did not start gain build")
    `GSP_ASSERT_SAME(a_done_in_mul, i_clk, i_rst_n, w_mac_done, r_state == S_MUL, "multiplier finished outside multiply state")
    `GSP_ASSERT_SAME(a_out_from_hold, i_clk, i_rst_n, $rose(o_out_valid), $past(r_state) == S_HOLD, "output raised without a finished result")

endmodule

@@ rtl/core/gsp_serial_mac.sv @@
`include "gain_scheduled_pd_steering_defines.svh"

module gsp_serial_mac import gsp_pkg::*; (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_start,
    input  logic signed [MacMcW-1:0]             i_a,
    input  logic signed [MacMcW-1:0]             i_b,
    input  logic [MacSteps-1:0]                  i_ma,
    input  logic [MacSteps-1:0]                  i_mb,
    output logic                                 o_done,
    output logic signed [MacHiW+MacSteps-1:0]    o_product
);

    logic                       r_busy;
    logic                       r_done;
    logic [MacCntW-1:0]         r_cnt;
    logic signed [MacHiW-1:0]   r_hi;
    logic [MacSteps-1:0]        r_lo;
    logic signed [MacMcW-1:0]   r_a;
    logic signed [MacMcW-1:0]   r_b;
    logic [MacSteps-1:0]        r_ma;
    logic [MacSteps-1:0]        r_mb;

    logic                       w_last;
    logic signed [MacHiW-1:0]   w_ext_a;
    logic signed [MacHiW-1:0]   w_ext_b;
    logic signed [MacHiW-1:0]   w_pa;
    logic signed [MacHiW-1:0]   w_pb;
    logic signed [MacHiW-1:0]   w_t;

    assign w_last  = (r_cnt == MacCntW'(MacSteps - 1));
    assign w_ext_a = {{(MacHiW - MacMcW){r_a[MacMcW-1]}}, r_a};
    assign w_ext_b = {{(MacHiW - MacMcW){r_b[MacMcW-1]}}, r_b};

    // sign bit of the multiplier carries negative weight
    always_comb begin
        w_pa = '0;
        w_pb = '0;
        if (r_ma[0]) begin
            w_pa = w_last ? -w_ext_a : w_ext_a;
        end
        if (r_mb[0]) begin
            w_pb = w_last ? -w_ext_b : w_ext_b;
        end
    end

    assign w_t = r_hi + w_pa + w_pb;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && w_last;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + MacCntW'(1);
                if (w_last) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_hi <= '0;
            r_lo <= '0;
            r_a  <= i_a;
            r_b  <= i_b;
            r_ma <= i_ma;
            r_mb <= i_mb;
        end else if (r_busy) begin
            r_hi <= w_t >>> 1;
            r_lo <= {w_t[0], r_lo[MacSteps-1:1]};
            r_ma <= r_ma >> 1;
            r_mb <= r_mb >> 1;
        end
    end

    assign o_done    = r_done;
    assign o_product = {r_hi, r_lo};

    `GSP_ASSERT_SAME(a_start_when_idle, i_clk, i_rst_n, i_start, !r_busy, "mac started while busy")
    `GSP_ASSERT_SAME(a_done_after_last, i_clk, i_rst_n, r_done, $past(r_busy) && $past(w_last), "mac done without final step")

endmodule
